// File: rtl/core/sva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_pkg
// Shared widths, face indexes, CORDIC arctangent table and a helper function
// for the sun vector angle pipeline.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int SAMPLE_W        = 10;
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int ANGLE_W         = 14;
  localparam int FACES           = 5;

  // face order of one word
  localparam int FACE_PX = 0;
  localparam int FACE_PY = 1;
  localparam int FACE_PZ = 2;
  localparam int FACE_NX = 3;
  localparam int FACE_NY = 4;

  localparam int SUM_W     = SAMPLE_W + 1;
  localparam int SQ_W      = 2 * SUM_W;
  localparam int S_W       = SQ_W + 2;
  localparam int MAG_FRAC  = 8;
  localparam int MAG_W     = S_W / 2 + MAG_FRAC;
  localparam int RAD_W     = 2 * MAG_W;
  localparam int Q_W       = 16;
  localparam int QQ_W      = 2 * Q_W;
  localparam int W_W       = Q_W + 1;
  localparam int COS_RAD_W = 2 * W_W;
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_PRE   = 8;
  localparam int CX_W      = 28;
  localparam int TH_W      = 27;
  localparam int SCALE_W   = 13;
  localparam int SCALE     = 5729;
  localparam int PROD_W    = TH_W - 1 + SCALE_W;
  localparam int ANGLE_FRAC = 24;
  localparam int ANGLE_MAX  = 9000;

  typedef logic [Q_W-1:0]         ratio_t;
  typedef logic signed [CX_W-1:0] cvec_t;
  typedef logic signed [TH_W-1:0] theta_t;

  // round(atan(2^-i) * 2^24)
  function automatic theta_t atan_entry(input logic [4:0] i);
    theta_t r;
    unique case (i)
      5'd0:    r = theta_t'(13176795);
      5'd1:    r = theta_t'(7778716);
      5'd2:    r = theta_t'(4110060);
      5'd3:    r = theta_t'(2086331);
      5'd4:    r = theta_t'(1047214);
      5'd5:    r = theta_t'(524117);
      5'd6:    r = theta_t'(262123);
      5'd7:    r = theta_t'(131069);
      5'd8:    r = theta_t'(65536);
      5'd9:    r = theta_t'(32768);
      5'd10:   r = theta_t'(16384);
      5'd11:   r = theta_t'(8192);
      5'd12:   r = theta_t'(4096);
      5'd13:   r = theta_t'(2048);
      5'd14:   r = theta_t'(1024);
      5'd15:   r = theta_t'(512);
      5'd16:   r = theta_t'(256);
      5'd17:   r = theta_t'(128);
      5'd18:   r = theta_t'(64);
      5'd19:   r = theta_t'(32);
      5'd20:   r = theta_t'(16);
      5'd21:   r = theta_t'(8);
      5'd22:   r = theta_t'(4);
      5'd23:   r = theta_t'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

  // shift right with the magnitude truncated toward zero
  function automatic cvec_t shr_tz(input cvec_t v, input int s);
    cvec_t m;
    m = v[CX_W-1] ? -v : v;
    m = m >> s;
    return v[CX_W-1] ? -m : m;
  endfunction

endpackage

// File: rtl/core/sva_isqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_isqrt_pipe
// Floor square root, one root bit per register stage, several lanes side by
// side, with a sideband word carried along.
// ----------------------------------------------------------------------------
module sva_isqrt_pipe #(
  parameter int VAL_W  = 40,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1,
  localparam int RT_W  = VAL_W / 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [VAL_W-1:0]  in_val [LANES],
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RT_W-1:0]   out_root [LANES],
  output logic [SIDE_W-1:0] out_side
);

  localparam int NST = RT_W;

  logic              v_r    [NST];
  logic              rdy    [NST+1];
  logic [VAL_W-1:0]  val_r  [NST][LANES];
  logic [RT_W:0]     rem_r  [NST][LANES];
  logic [RT_W-1:0]   root_r [NST][LANES];
  logic [SIDE_W-1:0] side_r [NST];

  logic [VAL_W-1:0]  p_val  [NST][LANES];
  logic [RT_W:0]     p_rem  [NST][LANES];
  logic [RT_W-1:0]   p_root [NST][LANES];
  logic [VAL_W-1:0]  val_nxt  [NST][LANES];
  logic [RT_W:0]     rem_nxt  [NST][LANES];
  logic [RT_W-1:0]   root_nxt [NST][LANES];

  always_comb begin
    rdy[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      p_val[0][l]  = in_val[l];
      p_rem[0][l]  = '0;
      p_root[0][l] = '0;
    end
    for (int k = 1; k < NST; k++) begin
      for (int l = 0; l < LANES; l++) begin
        p_val[k][l]  = val_r[k-1][l];
        p_rem[k][l]  = rem_r[k-1][l];
        p_root[k][l] = root_r[k-1][l];
      end
    end
  end

  // bring down two radicand bits, try (root << 2) | 1
  always_comb begin
    logic [RT_W+1:0] sh;
    logic [RT_W+1:0] tr;
    for (int k = 0; k < NST; k++) begin
      for (int l = 0; l < LANES; l++) begin
        sh = {p_rem[k][l][RT_W-1:0], p_val[k][l][VAL_W-1 -: 2]};
        tr = {p_root[k][l], 2'b01};
        if (sh >= tr) begin
          rem_nxt[k][l]  = (RT_W + 1)'(sh - tr);
          root_nxt[k][l] = {p_root[k][l][RT_W-2:0], 1'b1};
        end else begin
          rem_nxt[k][l]  = sh[RT_W:0];
          root_nxt[k][l] = {p_root[k][l][RT_W-2:0], 1'b0};
        end
        val_nxt[k][l] = p_val[k][l] << 2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) v_r[k] <= 1'b0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) side_r[0] <= in_side;
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) side_r[k] <= side_r[k-1];
    end
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) begin
        for (int l = 0; l < LANES; l++) begin
          val_r[k][l]  <= val_nxt[k][l];
          rem_r[k][l]  <= rem_nxt[k][l];
          root_r[k][l] <= root_nxt[k][l];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NST-1];
  assign out_side  = side_r[NST-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) out_root[l] = root_r[NST-1][l];
  end

endmodule

// File: rtl/core/sva_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_div_pipe
// Ratio of each face sample to the magnitude, 16 fraction bits, one quotient
// bit per register stage, five lanes sharing the divisor.
// ----------------------------------------------------------------------------
module sva_div_pipe import sva_pkg::*; #(
  parameter int SB = SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [MAG_W-1:0] in_mag,
  input  logic [SB-1:0]    in_smp [FACES],
  output logic             out_valid,
  input  logic             out_ready,
  output ratio_t           out_q [FACES]
);

  localparam int NST = Q_W;

  logic             v_r   [NST];
  logic             rdy   [NST+1];
  logic [MAG_W-1:0] mag_r [NST];
  logic [MAG_W-1:0] rem_r [NST][FACES];
  ratio_t           q_r   [NST][FACES];

  logic [MAG_W-1:0] p_mag [NST];
  logic [MAG_W-1:0] p_rem [NST][FACES];
  ratio_t           p_q   [NST][FACES];
  logic [MAG_W-1:0] rem_nxt [NST][FACES];
  ratio_t           q_nxt   [NST][FACES];

  always_comb begin
    rdy[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  // the partial remainder starts as sample << 8, already below the divisor
  always_comb begin
    p_mag[0] = in_mag;
    for (int l = 0; l < FACES; l++) begin
      p_rem[0][l] = MAG_W'({in_smp[l], {MAG_FRAC{1'b0}}});
      p_q[0][l]   = '0;
    end
    for (int k = 1; k < NST; k++) begin
      p_mag[k] = mag_r[k-1];
      for (int l = 0; l < FACES; l++) begin
        p_rem[k][l] = rem_r[k-1][l];
        p_q[k][l]   = q_r[k-1][l];
      end
    end
  end

  always_comb begin
    logic [MAG_W:0] t;
    logic           ge;
    for (int k = 0; k < NST; k++) begin
      for (int l = 0; l < FACES; l++) begin
        t  = {p_rem[k][l], 1'b0};
        ge = t >= {1'b0, p_mag[k]};
        rem_nxt[k][l] = ge ? MAG_W'(t - {1'b0, p_mag[k]}) : t[MAG_W-1:0];
        q_nxt[k][l]   = {p_q[k][l][Q_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) v_r[k] <= 1'b0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) begin
        mag_r[k] <= p_mag[k];
        for (int l = 0; l < FACES; l++) begin
          rem_r[k][l] <= rem_nxt[k][l];
          q_r[k][l]   <= q_nxt[k][l];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NST-1];
  always_comb begin
    for (int l = 0; l < FACES; l++) out_q[l] = q_r[NST-1][l];
  end

endmodule

// File: rtl/core/sva_cordic_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_cordic_pipe
// Vectoring CORDIC, one micro-rotation per register stage, five lanes:
// gives atan2(w, q) in radians with 24 fraction bits.
// ----------------------------------------------------------------------------
module sva_cordic_pipe import sva_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ratio_t         in_q [FACES],
  input  logic [W_W-1:0] in_w [FACES],
  output logic           out_valid,
  input  logic           out_ready,
  output theta_t         out_th [FACES]
);

  localparam int NST = CORDIC_STEPS;

  logic   v_r  [NST];
  logic   rdy  [NST+1];
  cvec_t  cx_r [NST][FACES];
  cvec_t  cy_r [NST][FACES];
  theta_t th_r [NST][FACES];

  cvec_t  p_cx [NST][FACES];
  cvec_t  p_cy [NST][FACES];
  theta_t p_th [NST][FACES];
  cvec_t  cx_nxt [NST][FACES];
  cvec_t  cy_nxt [NST][FACES];
  theta_t th_nxt [NST][FACES];

  always_comb begin
    rdy[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    for (int l = 0; l < FACES; l++) begin
      p_cx[0][l] = cvec_t'({in_q[l], {CORDIC_PRE{1'b0}}});
      p_cy[0][l] = cvec_t'({in_w[l], {CORDIC_PRE{1'b0}}});
      p_th[0][l] = '0;
    end
    for (int k = 1; k < NST; k++) begin
      for (int l = 0; l < FACES; l++) begin
        p_cx[k][l] = cx_r[k-1][l];
        p_cy[k][l] = cy_r[k-1][l];
        p_th[k][l] = th_r[k-1][l];
      end
    end
  end

  // rotate toward y = 0, accumulate the angle
  always_comb begin
    cvec_t dx;
    cvec_t dy;
    for (int k = 0; k < NST; k++) begin
      for (int l = 0; l < FACES; l++) begin
        dx = shr_tz(p_cy[k][l], k);
        dy = shr_tz(p_cx[k][l], k);
        if (!p_cy[k][l][CX_W-1]) begin
          cx_nxt[k][l] = p_cx[k][l] + dx;
          cy_nxt[k][l] = p_cy[k][l] - dy;
          th_nxt[k][l] = p_th[k][l] + atan_entry(5'(k));
        end else begin
          cx_nxt[k][l] = p_cx[k][l] - dx;
          cy_nxt[k][l] = p_cy[k][l] + dy;
          th_nxt[k][l] = p_th[k][l] - atan_entry(5'(k));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) v_r[k] <= 1'b0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) begin
        for (int l = 0; l < FACES; l++) begin
          cx_r[k][l] <= cx_nxt[k][l];
          cy_r[k][l] <= cy_nxt[k][l];
          th_r[k][l] <= th_nxt[k][l];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NST-1];
  always_comb begin
    for (int l = 0; l < FACES; l++) out_th[l] = th_r[NST-1][l];
  end

endmodule

// File: rtl/core/sun_vector_angle_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sun_vector_angle_calc
// Five face light samples in, five face angles (hundredths of a degree) out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) takes one word of five ADC samples,
//   +x, +y, +z, -x, -y. Result channel (out_valid / out_ready) gives one
//   word of five angles, acos(sample / magnitude) in 0.01 degree, 0..9000.
//   Every input word yields exactly one result word, in order.
//   A word passes 3 front stages (sums, squares, total), 20 magnitude
//   square-root stages, 1 offset stage, 16 divide stages, 2 stages for
//   1 - ratio^2, 17 square-root stages, 24 CORDIC stages and 2 scaling
//   stages. Unless the receiver stalls, one word enters every cycle, a rate
//   set by the stage-per-bit root and divide pipelines.
//   A stalled receiver holds the last stage; each stage keeps its word until
//   the next one frees, so empty slots fill up and in_ready drops only when
//   the whole pipeline is full. Nothing is lost or repeated.
//   Reset clears every stage valid bit; no state is kept between words.
//   Only the low SAMPLE_BITS bits of each sample take part.
// ----------------------------------------------------------------------------
module sun_vector_angle_calc import sva_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_pos_x_sample,
  input  logic [SAMPLE_W-1:0] in_pos_y_sample,
  input  logic [SAMPLE_W-1:0] in_pos_z_sample,
  input  logic [SAMPLE_W-1:0] in_neg_x_sample,
  input  logic [SAMPLE_W-1:0] in_neg_y_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ANGLE_W-1:0]  out_angle_pos_x,
  output logic [ANGLE_W-1:0]  out_angle_pos_y,
  output logic [ANGLE_W-1:0]  out_angle_pos_z,
  output logic [ANGLE_W-1:0]  out_angle_neg_x,
  output logic [ANGLE_W-1:0]  out_angle_neg_y
);

  // bits above the sample field never take part
  localparam int SB     = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int SIDE_W = FACES * SB;
  localparam int QS_W   = FACES * Q_W;

  // --------------------------------------------------------------------------
  // Front: face sums, squares, sum of squares
  // --------------------------------------------------------------------------
  logic [SB-1:0]    smp_in [FACES];
  logic             va_r   [3];
  logic             rdya   [4];
  logic [SUM_W-1:0] sx_r, sy_r, sz_r;
  logic [SQ_W-1:0]  sqx_r, sqy_r, sqz_r;
  logic [S_W-1:0]   ssum_r;
  logic [SB-1:0]    smp1_r [FACES];
  logic [SB-1:0]    smp2_r [FACES];
  logic [SB-1:0]    smp3_r [FACES];

  logic             mag_in_ready;
  logic [RAD_W-1:0] mag_rad [1];
  logic [SIDE_W-1:0] mag_side_in, mag_side_out;
  logic             mag_out_valid;
  logic             mag_out_ready;
  logic [MAG_W-1:0] mag_root [1];

  always_comb begin
    smp_in[FACE_PX] = in_pos_x_sample[SB-1:0];
    smp_in[FACE_PY] = in_pos_y_sample[SB-1:0];
    smp_in[FACE_PZ] = in_pos_z_sample[SB-1:0];
    smp_in[FACE_NX] = in_neg_x_sample[SB-1:0];
    smp_in[FACE_NY] = in_neg_y_sample[SB-1:0];
  end

  always_comb begin
    rdya[3] = mag_in_ready;
    for (int k = 2; k >= 0; k--) rdya[k] = !va_r[k] || rdya[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) va_r[k] <= 1'b0;
    end else begin
      if (rdya[0]) va_r[0] <= in_valid;
      if (rdya[1]) va_r[1] <= va_r[0];
      if (rdya[2]) va_r[2] <= va_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdya[0]) begin
      sx_r   <= SUM_W'(smp_in[FACE_PX]) + SUM_W'(smp_in[FACE_NX]);
      sy_r   <= SUM_W'(smp_in[FACE_PY]) + SUM_W'(smp_in[FACE_NY]);
      sz_r   <= SUM_W'(smp_in[FACE_PZ]);
      smp1_r <= smp_in;
    end
    if (rdya[1]) begin
      sqx_r  <= SQ_W'(sx_r) * SQ_W'(sx_r);
      sqy_r  <= SQ_W'(sy_r) * SQ_W'(sy_r);
      sqz_r  <= SQ_W'(sz_r) * SQ_W'(sz_r);
      smp2_r <= smp1_r;
    end
    if (rdya[2]) begin
      ssum_r <= S_W'(sqx_r) + S_W'(sqy_r) + S_W'(sqz_r);
      smp3_r <= smp2_r;
    end
  end

  // magnitude with 8 fraction bits: isqrt(S << 16)
  always_comb begin
    mag_rad[0] = {ssum_r, {(RAD_W - S_W){1'b0}}};
    for (int l = 0; l < FACES; l++) mag_side_in[l*SB +: SB] = smp3_r[l];
  end

  sva_isqrt_pipe #(
    .VAL_W  (RAD_W),
    .LANES  (1),
    .SIDE_W (SIDE_W)
  ) u_mag_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (va_r[2]),
    .in_ready  (mag_in_ready),
    .in_val    (mag_rad),
    .in_side   (mag_side_in),
    .out_valid (mag_out_valid),
    .out_ready (mag_out_ready),
    .out_root  (mag_root),
    .out_side  (mag_side_out)
  );

  // --------------------------------------------------------------------------
  // Add one (256 in this scaling) so the divisor is never zero
  // --------------------------------------------------------------------------
  logic             vb_r;
  logic             div_in_ready;
  logic [MAG_W-1:0] magp_r;
  logic [SB-1:0]    smp4_r [FACES];

  assign mag_out_ready = !vb_r || div_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (mag_out_ready) begin
      vb_r <= mag_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mag_out_ready) begin
      magp_r <= mag_root[0] + MAG_W'(1 << MAG_FRAC);
      for (int l = 0; l < FACES; l++) smp4_r[l] <= mag_side_out[l*SB +: SB];
    end
  end

  logic   div_out_valid;
  logic   div_out_ready;
  ratio_t div_q [FACES];

  sva_div_pipe #(
    .SB (SB)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vb_r),
    .in_ready  (div_in_ready),
    .in_mag    (magp_r),
    .in_smp    (smp4_r),
    .out_valid (div_out_valid),
    .out_ready (div_out_ready),
    .out_q     (div_q)
  );

  // --------------------------------------------------------------------------
  // 1 - ratio^2 in 32 fraction bits, then its root
  // --------------------------------------------------------------------------
  logic                 vc_r  [2];
  logic                 rdyc  [3];
  logic [QQ_W-1:0]      qq_r  [FACES];
  ratio_t               qc1_r [FACES];
  logic [COS_RAD_W-1:0] rad_r [FACES];
  ratio_t               qc2_r [FACES];
  logic                 sin_in_ready;
  logic [QS_W-1:0]      sin_side_in, sin_side_out;
  logic                 sin_out_valid;
  logic                 sin_out_ready;
  logic [W_W-1:0]       sin_root [FACES];
  ratio_t               qd_q [FACES];

  always_comb begin
    rdyc[2] = sin_in_ready;
    for (int k = 1; k >= 0; k--) rdyc[k] = !vc_r[k] || rdyc[k+1];
  end
  assign div_out_ready = rdyc[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r[0] <= 1'b0;
      vc_r[1] <= 1'b0;
    end else begin
      if (rdyc[0]) vc_r[0] <= div_out_valid;
      if (rdyc[1]) vc_r[1] <= vc_r[0];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < FACES; l++) begin
      if (rdyc[0]) begin
        qq_r[l]  <= QQ_W'(div_q[l]) * QQ_W'(div_q[l]);
        qc1_r[l] <= div_q[l];
      end
      if (rdyc[1]) begin
        rad_r[l] <= (COS_RAD_W'(1) << QQ_W) - COS_RAD_W'(qq_r[l]);
        qc2_r[l] <= qc1_r[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < FACES; l++) begin
      sin_side_in[l*Q_W +: Q_W] = qc2_r[l];
      qd_q[l] = sin_side_out[l*Q_W +: Q_W];
    end
  end

  sva_isqrt_pipe #(
    .VAL_W  (COS_RAD_W),
    .LANES  (FACES),
    .SIDE_W (QS_W)
  ) u_sin_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vc_r[1]),
    .in_ready  (sin_in_ready),
    .in_val    (rad_r),
    .in_side   (sin_side_in),
    .out_valid (sin_out_valid),
    .out_ready (sin_out_ready),
    .out_root  (sin_root),
    .out_side  (sin_side_out)
  );

  // --------------------------------------------------------------------------
  // Angle by CORDIC vectoring
  // --------------------------------------------------------------------------
  logic   cor_out_valid;
  logic   cor_out_ready;
  theta_t cor_th [FACES];

  sva_cordic_pipe u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sin_out_valid),
    .in_ready  (sin_out_ready),
    .in_q      (qd_q),
    .in_w      (sin_root),
    .out_valid (cor_out_valid),
    .out_ready (cor_out_ready),
    .out_th    (cor_th)
  );

  // --------------------------------------------------------------------------
  // Scale by 5729 / 2^24 with round half up, drop negative angles, clamp
  // --------------------------------------------------------------------------
  logic               vd_r   [2];
  logic               rdyd   [3];
  logic               pos_r  [FACES];
  logic [PROD_W-1:0]  prod_r [FACES];
  logic [ANGLE_W-1:0] ang_r  [FACES];

  always_comb begin
    rdyd[2] = out_ready;
    for (int k = 1; k >= 0; k--) rdyd[k] = !vd_r[k] || rdyd[k+1];
  end
  assign cor_out_ready = rdyd[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
      vd_r[1] <= 1'b0;
    end else begin
      if (rdyd[0]) vd_r[0] <= cor_out_valid;
      if (rdyd[1]) vd_r[1] <= vd_r[0];
    end
  end

  always_ff @(posedge clk) begin
    logic [PROD_W:0]     rnd;
    logic [PROD_W-ANGLE_FRAC:0] whole;
    for (int l = 0; l < FACES; l++) begin
      if (rdyd[0]) begin
        pos_r[l]  <= !cor_th[l][TH_W-1] && (cor_th[l] != '0);
        prod_r[l] <= PROD_W'(cor_th[l][TH_W-2:0]) * PROD_W'(SCALE);
      end
      if (rdyd[1]) begin
        rnd   = (PROD_W + 1)'(prod_r[l]) + ((PROD_W + 1)'(1) << (ANGLE_FRAC - 1));
        whole = rnd[PROD_W:ANGLE_FRAC];
        if (!pos_r[l]) begin
          ang_r[l] <= '0;
        end else if (whole > (PROD_W - ANGLE_FRAC + 1)'(ANGLE_MAX)) begin
          ang_r[l] <= ANGLE_W'(ANGLE_MAX);
        end else begin
          ang_r[l] <= whole[ANGLE_W-1:0];
        end
      end
    end
  end

  assign in_ready        = rdya[0];
  assign out_valid       = vd_r[1];
  assign out_angle_pos_x = ang_r[FACE_PX];
  assign out_angle_pos_y = ang_r[FACE_PY];
  assign out_angle_pos_z = ang_r[FACE_PZ];
  assign out_angle_neg_x = ang_r[FACE_NX];
  assign out_angle_neg_y = ang_r[FACE_NY];

endmodule
